// ===== rtl/core/lpk_pkg.sv =====
// shared types, constants and codes for the light top-k selector
package lpk_pkg;

    localparam int ID_W       = 16;
    localparam int PRIO_W     = 8;
    localparam int DIST_W     = 32;
    localparam int RADIUS_W   = 16;
    localparam int RANK_W     = 3;
    localparam int S_DATA_W   = 72;
    localparam int M_DATA_W   = 64;
    localparam int M_PAD_W    = M_DATA_W - (ID_W + PRIO_W + DIST_W + RANK_W);

    localparam int KEEP_COUNT_DEF  = 8;
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic [DIST_W-1:0] sq_dist;
    } t_light;

    typedef struct packed {
        t_light light;
        logic   keep;
        logic   last;
    } t_q_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } t_back_state;

endpackage

// ===== rtl/core/lpk_front.sv =====
// front end: takes requests, squares the radius, classifies and queues survivors and batch ends
module lpk_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [lpk_pkg::S_DATA_W-1:0]    i_data,
    input  logic                            i_user,
    input  logic                            i_last,
    input  lpk_pkg::t_q_status              i_q_stat,
    output logic                            o_push,
    output lpk_pkg::t_q_entry               o_entry
);
    import lpk_pkg::*;

    logic                  r_valid;
    logic                  n_valid;
    t_light                r_light;
    logic                  r_ambient;
    logic                  r_last;
    logic [DIST_W-1:0]     r_rad_sq;
    logic [RADIUS_W-1:0]   w_radius;
    logic                  w_keep;
    logic                  w_needed;
    logic                  w_drain;
    logic                  w_take;

    assign w_radius = i_data[ID_W+PRIO_W+DIST_W +: RADIUS_W];

    // dropped items that do not close a batch never enter the queue
    assign w_keep   = !r_ambient && (r_light.sq_dist <= r_rad_sq);
    assign w_needed = w_keep || r_last;
    assign w_drain  = r_valid && (!w_needed || !i_q_stat.full);
    assign o_ready  = !r_valid || w_drain;
    assign w_take   = i_valid && o_ready;

    assign o_push        = r_valid && w_needed && !i_q_stat.full;
    assign o_entry.light = r_light;
    assign o_entry.keep  = w_keep;
    assign o_entry.last  = r_last;

    always_comb begin
        n_valid = r_valid;
        if (w_take) begin
            n_valid = 1'b1;
        end else if (w_drain) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_light.id      <= i_data[0 +: ID_W];
            r_light.prio    <= i_data[ID_W +: PRIO_W];
            r_light.sq_dist <= i_data[ID_W+PRIO_W +: DIST_W];
            r_ambient       <= i_user;
            r_last          <= i_last;
            r_rad_sq        <= DIST_W'(w_radius) * DIST_W'(w_radius);
        end
    end

endmodule

// ===== rtl/core/lpk_queue.sv =====
// short first-in first-out queue between the front and the back end
module lpk_queue #(
    parameter int DEPTH = lpk_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  lpk_pkg::t_q_entry   i_entry,
    input  logic                i_pop,
    output lpk_pkg::t_q_entry   o_entry,
    output lpk_pkg::t_q_status  o_stat
);
    import lpk_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);

    t_q_entry          r_mem [DEPTH];
    logic [AW-1:0]     r_wr_ptr;
    logic [AW-1:0]     n_wr_ptr;
    logic [AW-1:0]     r_rd_ptr;
    logic [AW-1:0]     n_rd_ptr;
    logic [FW-1:0]     r_fill;
    logic [FW-1:0]     n_fill;
    logic              w_push;
    logic              w_pop;

    assign o_stat.full  = (r_fill == FW'(DEPTH));
    assign o_stat.empty = (r_fill == '0);
    assign w_push       = i_push && !o_stat.full;
    assign w_pop        = i_pop && !o_stat.empty;
    assign o_entry      = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (w_pop && !w_push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// ===== rtl/core/lpk_back.sv =====
// back end: sorted insertion cells, emission sequencer and output register
module lpk_back #(
    parameter int KEEP_COUNT = lpk_pkg::KEEP_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lpk_pkg::t_q_entry               i_entry,
    input  lpk_pkg::t_q_status              i_q_stat,
    output logic                            o_pop,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [lpk_pkg::M_DATA_W-1:0]    o_data,
    output logic                            o_user,
    output logic                            o_last
);
    import lpk_pkg::*;

    localparam int CNT_W = $clog2(KEEP_COUNT + 1);

    t_back_state          r_state;
    t_back_state          n_state;
    t_light               r_cell [KEEP_COUNT];
    t_light               n_cell [KEEP_COUNT];
    t_light               w_ins  [KEEP_COUNT];
    logic [KEEP_COUNT-1:0] w_ahead;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic [RANK_W-1:0]    r_rank;
    logic [RANK_W-1:0]    n_rank;
    logic                 r_m_valid;
    logic                 n_m_valid;
    logic                 w_load_out;
    t_light               r_m_light;
    t_light               n_m_light;
    logic [RANK_W-1:0]    r_m_rank;
    logic [RANK_W-1:0]    n_m_rank;
    logic                 r_m_user;
    logic                 n_m_user;
    logic                 r_m_last;
    logic                 n_m_last;
    logic                 w_out_free;

    // kept cell a stays ahead of an arriving light b: ties keep arrival order
    function automatic logic stays_ahead(input t_light a, input t_light b);
        logic result;
        if (a.prio != b.prio) begin
            result = (a.prio < b.prio);
        end else begin
            result = (a.sq_dist <= b.sq_dist);
        end
        return result;
    endfunction

    // every cell compares against the new light in parallel, then shifts or loads
    always_comb begin
        for (int i = 0; i < KEEP_COUNT; i++) begin
            w_ahead[i] = (CNT_W'(i) < r_count) && stays_ahead(r_cell[i], i_entry.light);
        end
        w_ins[0] = w_ahead[0] ? r_cell[0] : i_entry.light;
        for (int i = 1; i < KEEP_COUNT; i++) begin
            if (w_ahead[i]) begin
                w_ins[i] = r_cell[i];
            end else if (w_ahead[i-1]) begin
                w_ins[i] = i_entry.light;
            end else begin
                w_ins[i] = r_cell[i-1];
            end
        end
    end

    assign w_out_free = !r_m_valid || i_ready;

    always_comb begin
        n_state    = r_state;
        n_cell     = r_cell;
        n_count    = r_count;
        n_rank     = r_rank;
        o_pop      = 1'b0;
        w_load_out = 1'b0;
        n_m_light  = r_m_light;
        n_m_rank   = r_m_rank;
        n_m_user   = r_m_user;
        n_m_last   = r_m_last;
        unique case (r_state)
            ST_LOAD: begin
                if (!i_q_stat.empty) begin
                    o_pop = 1'b1;
                    // all cells ahead means the list is full and the light ranks last
                    if (i_entry.keep && !w_ahead[KEEP_COUNT-1]) begin
                        n_cell = w_ins;
                        if (r_count < CNT_W'(KEEP_COUNT)) begin
                            n_count = r_count + 1'b1;
                        end
                    end
                    if (i_entry.last) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    if (r_count == '0) begin
                        // empty batch: one invalid result closes it
                        n_m_light = '0;
                        n_m_rank  = '0;
                        n_m_user  = 1'b0;
                        n_m_last  = 1'b1;
                        n_state   = ST_LOAD;
                    end else begin
                        n_m_light = r_cell[0];
                        n_m_rank  = r_rank;
                        n_m_user  = 1'b1;
                        n_m_last  = (r_count == CNT_W'(1));
                        for (int i = 0; i < KEEP_COUNT - 1; i++) begin
                            n_cell[i] = r_cell[i+1];
                        end
                        n_count = r_count - 1'b1;
                        n_rank  = r_rank + 1'b1;
                        if (r_count == CNT_W'(1)) begin
                            n_rank  = '0;
                            n_state = ST_LOAD;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_comb begin
        if (w_load_out) begin
            n_m_valid = 1'b1;
        end else if (i_ready) begin
            n_m_valid = 1'b0;
        end else begin
            n_m_valid = r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_count   <= '0;
            r_rank    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_rank    <= n_rank;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell    <= n_cell;
        r_m_light <= n_m_light;
        r_m_rank  <= n_m_rank;
        r_m_user  <= n_m_user;
        r_m_last  <= n_m_last;
    end

    assign o_valid = r_m_valid;
    assign o_data  = {{M_PAD_W{1'b0}}, r_m_rank, r_m_light.sq_dist, r_m_light.prio,
                      r_m_light.id};
    assign o_user  = r_m_user;
    assign o_last  = r_m_last;

endmodule

// ===== rtl/core/light_priority_top_k_select.sv =====
// top level of the light top-k selector: front end, queue and back end
//
//  channel | dir | tdata (low bit up)                           | tuser        | tlast
//  s_      | in  | light_id, light_priority, sq_distance,       | ambient_only | batch_last
//          |     | reach_radius (72 bits)                       |              |
//  m_      | out | out_light_id, out_priority, out_distance,    | out_valid    | out_last
//          |     | out_rank, zero pad (64 bits)                 |              |
//
// the front end takes one request per cycle while the queue has room; the back end
// inserts one queued light per cycle through KEEP_COUNT parallel compare-and-shift
// cells. on batch_last the back end emits max(1, kept) results, one per cycle while
// the output is not stalled, and takes no queued light meanwhile; the queue of
// QUEUE_DEPTH entries absorbs the front. a request passes the front register and a
// queue entry into the cells; a batch's results leave through the output register.
// reset is synchronous and active low; it empties the queue and the kept list.
// either side may stall at any time without loss.
module light_priority_top_k_select #(
    parameter int KEEP_COUNT  = lpk_pkg::KEEP_COUNT_DEF,
    parameter int QUEUE_DEPTH = lpk_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // light_id, light_priority, sq_distance, reach_radius
    input  logic [lpk_pkg::S_DATA_W-1:0]    s_tdata,
    // ambient_only
    input  logic                            s_tuser,
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_light_id, out_priority, out_distance, out_rank, zero pad
    output logic [lpk_pkg::M_DATA_W-1:0]    m_tdata,
    // out_valid
    output logic                            m_tuser,
    output logic                            m_tlast
);
    import lpk_pkg::*;

    t_q_status  w_q_stat;
    t_q_entry   w_push_entry;
    t_q_entry   w_pop_entry;
    logic       w_push;
    logic       w_pop;

    lpk_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_tvalid),
        .o_ready  (s_tready),
        .i_data   (s_tdata),
        .i_user   (s_tuser),
        .i_last   (s_tlast),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_entry  (w_push_entry)
    );

    lpk_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_entry (w_pop_entry),
        .o_stat  (w_q_stat)
    );

    lpk_back #(
        .KEEP_COUNT (KEEP_COUNT)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_entry  (w_pop_entry),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_valid  (m_tvalid),
        .i_ready  (m_tready),
        .o_data   (m_tdata),
        .o_user   (m_tuser),
        .o_last   (m_tlast)
    );

`ifndef NO_ASSERTIONS
    // an invalid result only closes an empty batch and carries zero fields
    a_invalid_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tuser) |-> (m_tlast && (m_tdata == '0)))
        else $error("invalid result not last or not zero");

    // the front end never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_stat.full)
        else $error("queue push while full");

    // ranks stay within the kept list
    a_rank_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[ID_W+PRIO_W+DIST_W +: RANK_W] <= RANK_W'(KEEP_COUNT - 1)))
        else $error("rank beyond kept list");

    // a result following an accepted non-last result ranks one higher
    a_rank_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tready && m_tuser && !m_tlast) |=>
        (m_tdata[ID_W+PRIO_W+DIST_W +: RANK_W] ==
         $past(m_tdata[ID_W+PRIO_W+DIST_W +: RANK_W]) + 1'b1) || !m_tvalid)
        else $error("rank sequence broken");
`endif

endmodule

// ===== bench/tb_light_priority_top_k_select.sv =====
// self-checking testbench for the light top-k selector
module tb_light_priority_top_k_select;
    timeunit 1ns;
    timeprecision 1ps;

    import lpk_pkg::*;

    localparam int KEEP        = KEEP_COUNT_DEF;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic [DIST_W-1:0] sq_dist;
        logic [RANK_W-1:0] rank;
        logic              valid;
        logic              last;
    } t_pick;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    // light_id, light_priority, sq_distance, reach_radius
    logic [S_DATA_W-1:0]   s_tdata;
    // ambient_only
    logic                  s_tuser;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    // out_light_id, out_priority, out_distance, out_rank, zero pad
    logic [M_DATA_W-1:0]   m_tdata;
    // out_valid
    logic                  m_tuser;
    logic                  m_tlast;

    // model of the kept list, best first
    t_light shortlist [KEEP];
    int     shortlist_n;
    t_pick  pick_q [$];

    int errors;
    int cycles;
    bit src_gaps;
    bit sink_gaps;
    int hold_req;

    light_priority_top_k_select DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // append one expected result at the tail
    function automatic void queue_pick(t_pick p);
        pick_q = {pick_q, p};
    endfunction

    // insert one accepted light into the model and, on batch end, queue the picks
    function automatic void take_light(t_light c, logic amb, logic [RADIUS_W-1:0] rad,
                                       logic last);
        logic [DIST_W-1:0] reach_sq;
        int                pos;
        t_pick             p;
        reach_sq = 32'(rad) * 32'(rad);
        if (!amb && c.sq_dist <= reach_sq) begin
            pos = 0;
            // equal priority and distance: the newcomer goes behind
            while (pos < shortlist_n && (shortlist[pos].prio < c.prio ||
                   (shortlist[pos].prio == c.prio && shortlist[pos].sq_dist <= c.sq_dist)))
                pos++;
            if (pos < KEEP) begin
                if (shortlist_n < KEEP) shortlist_n++;
                for (int i = shortlist_n - 1; i > pos; i--) shortlist[i] = shortlist[i-1];
                shortlist[pos] = c;
            end
        end
        if (last) begin
            if (shortlist_n == 0) begin
                p = '{id: '0, prio: '0, sq_dist: '0, rank: '0, valid: 1'b0, last: 1'b1};
                queue_pick(p);
            end else begin
                for (int k = 0; k < shortlist_n; k++) begin
                    p.id      = shortlist[k].id;
                    p.prio    = shortlist[k].prio;
                    p.sq_dist = shortlist[k].sq_dist;
                    p.rank    = RANK_W'(k);
                    p.valid   = 1'b1;
                    p.last    = (k == shortlist_n - 1);
                    queue_pick(p);
                end
            end
            shortlist_n = 0;
        end
    endfunction

    task automatic send_light(input logic [ID_W-1:0] id, input logic amb,
                              input logic [PRIO_W-1:0] prio, input logic [DIST_W-1:0] sq_dist,
                              input logic [RADIUS_W-1:0] rad, input logic last);
        int     gap;
        t_light c;
        gap = src_gaps ? $urandom_range(0, 11) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {rad, sq_dist, prio, id};
        s_tuser  <= amb;
        s_tlast  <= last;
        do @(posedge i_clk); while (s_tready !== 1'b1);
        c.id      = id;
        c.prio    = prio;
        c.sq_dist = sq_dist;
        take_light(c, amb, rad, last);
    endtask

    // tight draws crowd priority and distance so ties and overflow are common
    task automatic send_random_light(input logic last, input bit tight);
        logic [RADIUS_W-1:0] rad;
        logic [DIST_W-1:0]   reach_sq;
        logic [DIST_W-1:0]   sq_dist;
        logic [PRIO_W-1:0]   prio;
        rad      = RADIUS_W'($urandom);
        reach_sq = 32'(rad) * 32'(rad);
        prio     = tight ? PRIO_W'($urandom_range(0, 3)) : PRIO_W'($urandom);
        case ($urandom_range(0, 5))
            0: sq_dist = $urandom;
            1: sq_dist = reach_sq;
            2: sq_dist = reach_sq + 1;
            default: sq_dist = $urandom_range(reach_sq, 0);
        endcase
        if (tight && rad > 2) sq_dist = $urandom_range(0, 3);
        send_light(ID_W'($urandom), $urandom_range(0, 7) == 0, prio, sq_dist, rad, last);
    endtask

    task automatic test_empty_batches();
        // ambient-only last request, then an out-of-reach one
        send_light(16'h0001, 1'b1, 8'h00, 32'h0, 16'h0100, 1'b1);
        send_light(16'h0002, 1'b0, 8'h00, 32'h1, 16'h0000, 1'b1);
    endtask

    task automatic test_ranking_edges();
        src_gaps = 1'b0;
        send_light(16'hFFFF, 1'b0, 8'hFF, 32'hFFFE_0001, 16'hFFFF, 1'b0);
        send_light(16'h0001, 1'b0, 8'h00, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        send_light(16'h0002, 1'b0, 8'h00, 32'h0,         16'h0000, 1'b0);
        send_light(16'h0003, 1'b0, 8'h05, 32'd100,       16'd10,   1'b0);
        send_light(16'h0004, 1'b0, 8'h05, 32'd100,       16'd10,   1'b0);
        send_light(16'h0005, 1'b1, 8'h05, 32'd100,       16'd10,   1'b0);
        send_light(16'h0006, 1'b0, 8'h05, 32'd99,        16'd10,   1'b0);
        send_light(16'h0007, 1'b0, 8'h04, 32'd200,       16'd15,   1'b0);
        send_light(16'h0008, 1'b0, 8'hFF, 32'h0,         16'd1,    1'b0);
        send_light(16'h0009, 1'b0, 8'h05, 32'd100,       16'd10,   1'b0);
        // list full: the worst falls off
        send_light(16'h000A, 1'b0, 8'h06, 32'h0,         16'h0000, 1'b0);
        // ranks behind every kept light, dropped
        send_light(16'h000B, 1'b0, 8'hFF, 32'hFFFE_0001, 16'hFFFF, 1'b0);
        // last request is inserted before the list goes out
        send_light(16'h0000, 1'b0, 8'h00, 32'h0,         16'h0000, 1'b1);
        src_gaps = 1'b1;
        send_light(16'h1234, 1'b0, 8'h80, 32'h8000_0000, 16'hB505, 1'b1);
        send_light(16'hA5A5, 1'b0, 8'h7F, 32'h7FFF_FFFF, 16'hFFFF, 1'b0);
        send_light(16'h5A5A, 1'b0, 8'h80, 32'h0000_0010, 16'h0004, 1'b1);
    endtask

    task automatic test_random_batches(input int n_items);
        int  sent;
        int  len;
        bit  tight;
        sent = 0;
        while (sent < n_items) begin
            len       = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20)
                                                     : $urandom_range(1, 8);
            src_gaps  = $urandom_range(0, 2) != 0;
            sink_gaps = $urandom_range(0, 2) != 0;
            tight     = $urandom_range(0, 2) == 0;
            for (int i = 0; i < len; i++) send_random_light(i == len - 1, tight);
            sent += len;
        end
    endtask

    task automatic test_input_stall();
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        hold_req  = 200;
        for (int i = 0; i < 6; i++)  send_random_light(i == 5, 1'b0);
        // the output is held, so these back up into the queue and stall the input
        for (int i = 0; i < 14; i++) send_random_light(i == 13, 1'b1);
    endtask

    // receiver: random stalls, plus a long hold-off on demand
    initial begin : sink_drive
        int stall;
        m_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            stall = sink_gaps ? $urandom_range(0, 11) : 0;
            if (hold_req > 0) begin
                stall    = hold_req;
                hold_req = 0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (m_tvalid !== 1'b1);
        end
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch expected %h actual %h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : check_picks
        t_pick want;
        if (i_rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            if (pick_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result expected none actual %h user %b last %b",
                         $time, m_tdata, m_tuser, m_tlast);
            end else begin
                want = pick_q.pop_front();
                check_field("light_id", 32'(want.id),    32'(m_tdata[15:0]));
                check_field("priority", 32'(want.prio),  32'(m_tdata[23:16]));
                check_field("distance", want.sq_dist,    m_tdata[55:24]);
                check_field("rank",     32'(want.rank),  32'(m_tdata[58:56]));
                check_field("valid",    32'(want.valid), 32'(m_tuser));
                check_field("last",     32'(want.last),  32'(m_tlast));
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        s_tlast     = 1'b0;
        shortlist_n = 0;
        errors      = 0;
        cycles      = 0;
        src_gaps    = 1'b1;
        sink_gaps   = 1'b1;
        hold_req    = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_batches();
        test_ranking_edges();
        test_random_batches(220);
        test_input_stall();

        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pick_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
